// File: rtl/swfr_pkg.sv
`default_nettype none

package swfr_pkg;

    // Field and register widths.
    localparam int FC_W       = 8;
    localparam int TS_W       = 48;
    localparam int RATE_W     = 24;
    localparam int FRAC_W     = 8;
    localparam int WARM_W     = 16;
    localparam int WCNT_W     = 17;
    localparam int TPS_W      = 30;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 30;

    // Default ring depth.
    localparam int DEF_QUEUE_DEPTH = 16;

    // Reset values of the configuration registers.
    localparam logic [WARM_W-1:0] WARM_RESET = '0;
    localparam logic [TPS_W-1:0]  TPS_RESET  = TPS_W'(1000000);

    // Saturated rate.
    localparam logic [RATE_W-1:0] RATE_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_FRAMES    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 1'b1;

    // One ring entry as stored in memory.
    typedef struct packed {
        logic [FC_W-1:0] frames;
        logic [TS_W-1:0] stamp;
    } t_entry;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_OLD,
        S_WRITE,
        S_CHECK,
        S_MUL,
        S_DIV_GO,
        S_DIV,
        S_DONE
    } t_state;

    // Divider control and status.
    typedef struct packed {
        logic start;
    } t_div_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// File: rtl/swfr_in_if.sv
`default_nettype none

interface swfr_in_if;
    import swfr_pkg::*;

    logic            valid;
    logic            ready;
    logic [FC_W-1:0] frame_count;
    logic [TS_W-1:0] time_ticks;

    modport source (output valid, output frame_count, output time_ticks, input ready);
    modport sink   (input valid, input frame_count, input time_ticks, output ready);
endinterface

`default_nettype wire

// File: rtl/swfr_out_if.sv
`default_nettype none

interface swfr_out_if;
    import swfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] rate_q8;
    logic              updated;

    modport source (output valid, output rate_q8, output updated, input ready);
    modport sink   (input valid, input rate_q8, input updated, output ready);
endinterface

`default_nettype wire

// File: rtl/swfr_ram.sv
`default_nettype none

module swfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                       i_clk,
    input  wire                       i_wr_en,
    input  wire [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  wire [WIDTH-1:0]           i_wr_data,
    input  wire                       i_rd_en,
    input  wire [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [WIDTH-1:0]          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/swfr_divider.sv
`default_nettype none

module swfr_divider
    import swfr_pkg::*;
#(
    parameter int DIVD_W = 50
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_div_ctrl          i_ctrl,
    input  wire [DIVD_W-1:0]   i_dividend,
    input  wire [TS_W-1:0]     i_divisor,
    output t_div_stat          o_stat,
    output logic [RATE_W-1:0]  o_quotient
);

    localparam int CNT_W = $clog2(RATE_W + 1);

    logic [TS_W-1:0]   r_rem;
    logic [RATE_W-1:0] r_low;
    logic [RATE_W-1:0] r_quot;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [TS_W:0]     w_a;
    logic [TS_W+1:0]   w_diff;
    logic              w_ge;

    // Shared subtract-compare. At start it compares the dividend bits above the
    // quotient field with the divisor, which tells whether the quotient fits.
    // Each later step shifts in one dividend bit and subtracts when possible.
    always_comb begin
        if (i_ctrl.start) begin
            w_a = (TS_W + 1)'(i_dividend[DIVD_W-1:RATE_W]);
        end else begin
            w_a = {r_rem, r_low[RATE_W-1]};
        end
        w_diff = {1'b0, w_a} - {2'b00, i_divisor};
        w_ge   = !w_diff[TS_W+1];
    end

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                if (w_ge) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CNT_W'(RATE_W);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_rem  <= w_a[TS_W-1:0];
            r_low  <= i_dividend[RATE_W-1:0];
            r_quot <= w_ge ? RATE_MAX : '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[TS_W-1:0] : w_a[TS_W-1:0];
            r_low  <= {r_low[RATE_W-2:0], 1'b0};
            r_quot <= {r_quot[RATE_W-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quot;

endmodule

`default_nettype wire

// File: rtl/sliding_window_frame_rate_meter_core.sv
`default_nettype none

// Sliding-window frame rate meter. Each input transaction carries the frames
// rendered since the last report and a 48-bit timestamp in ticks; each one gives
// exactly one output transaction with the current rate in frames per second as
// unsigned 16.8 fixed point, saturating at its maximum, and a flag telling
// whether the rate was recomputed. After reset the first warmup_frames frames
// are only counted. Later reports go into a ring of QUEUE_DEPTH entries, and the
// rate is taken over the window between the oldest stored report and the new
// one. A first stored report or a zero interval keeps the previous rate. A
// recomputed rate comes from the 24-step restoring division that shares one
// subtract-compare unit, which runs no steps when the quotient saturates. A
// new input is accepted only while the sequencer is idle, and the output
// register lets it start while the previous result is still waiting.
// Configuration writes take effect at once and should be made between
// transactions.
module sliding_window_frame_rate_meter_core
    import swfr_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]   i_cfg_data,
    swfr_in_if.sink                i_in,
    swfr_out_if.source             o_out
);

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = $clog2(QUEUE_DEPTH * 255 + 1);
    localparam int PROD_W = SUM_W + TPS_W;
    localparam int DIVD_W = PROD_W + FRAC_W;

    // Configuration registers.
    logic [WARM_W-1:0] r_warmup_frames;
    logic [TPS_W-1:0]  r_tps;

    // Measuring state.
    logic [WCNT_W-1:0] r_warm_cnt;
    logic [FILL_W-1:0] r_fill;
    logic [IDX_W-1:0]  r_oldest;
    logic [SUM_W-1:0]  r_sum;
    logic [RATE_W-1:0] r_rate;

    // Current transaction.
    logic [FC_W-1:0]   r_fc;
    logic [TS_W-1:0]   r_ts;
    logic              r_first;
    logic              r_upd;
    logic [TS_W-1:0]   r_interval;
    logic [SUM_W-1:0]  r_num;
    logic [PROD_W-1:0] r_prod;

    // Output register.
    logic              r_out_valid;
    logic [RATE_W-1:0] r_out_rate;
    logic              r_out_upd;

    t_state r_state;
    t_state n_state;

    // Decoded conditions.
    logic              w_in_fire;
    logic              w_warming;
    logic              w_full;
    logic [IDX_W-1:0]  w_next_oldest;
    logic              w_out_free;
    t_entry            w_rd_entry;
    t_entry            w_wr_entry;
    logic [TS_W-1:0]   w_interval;

    // Memory and divider controls.
    logic              w_wr_en;
    logic [IDX_W-1:0]  w_wr_addr;
    logic              w_rd_en;
    logic [IDX_W-1:0]  w_rd_addr;
    logic [$bits(t_entry)-1:0] w_rd_data;
    t_div_ctrl         w_div_ctrl;
    t_div_stat         w_div_stat;
    logic [RATE_W-1:0] w_quot;

    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_warming  = r_warm_cnt < {1'b0, r_warmup_frames};
    assign w_full     = r_fill == FILL_W'(QUEUE_DEPTH);
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_rd_entry = t_entry'(w_rd_data);
    assign w_interval = r_ts - w_rd_entry.stamp;
    assign w_next_oldest = (r_oldest == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_oldest + 1'b1;
    assign w_wr_entry.frames = r_fc;
    assign w_wr_entry.stamp  = r_ts;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_state = w_warming ? S_DONE : S_RD_OLD;
                end
            end
            S_RD_OLD: n_state = S_WRITE;
            S_WRITE:  n_state = S_CHECK;
            S_CHECK: begin
                if (r_first || (w_interval == '0)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL:    n_state = S_DIV_GO;
            S_DIV_GO: n_state = S_DIV;
            S_DIV: begin
                if (w_div_stat.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        i_in.ready       = 1'b0;
        w_wr_en          = 1'b0;
        w_wr_addr        = w_full ? r_oldest : r_fill[IDX_W-1:0];
        w_rd_en          = 1'b0;
        w_rd_addr        = r_oldest;
        w_div_ctrl.start = 1'b0;
        case (r_state)
            S_IDLE:   i_in.ready = 1'b1;
            S_RD_OLD: w_rd_en = 1'b1;
            S_WRITE: begin
                w_wr_en   = 1'b1;
                w_rd_en   = 1'b1;
                w_rd_addr = w_full ? w_next_oldest : '0;
            end
            S_DIV_GO: w_div_ctrl.start = 1'b1;
            default: begin
                i_in.ready = 1'b0;
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warmup_frames <= WARM_RESET;
            r_tps           <= TPS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WARMUP_FRAMES:    r_warmup_frames <= i_cfg_data[WARM_W-1:0];
                CFG_TICKS_PER_SECOND: r_tps           <= i_cfg_data[TPS_W-1:0];
                default: begin
                    r_tps <= r_tps;
                end
            endcase
        end
    end

    // Sequencer and measuring state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_warm_cnt  <= '0;
            r_fill      <= '0;
            r_oldest    <= '0;
            r_sum       <= '0;
            r_rate      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // A finished transaction loads the output register once it is free.
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_fire && w_warming) begin
                        r_warm_cnt <= r_warm_cnt + WCNT_W'(i_in.frame_count);
                    end
                end
                S_WRITE: begin
                    if (w_full) begin
                        r_sum    <= r_sum - SUM_W'(w_rd_entry.frames) + SUM_W'(r_fc);
                        r_oldest <= w_next_oldest;
                    end else begin
                        r_sum  <= r_sum + SUM_W'(r_fc);
                        r_fill <= r_fill + 1'b1;
                    end
                end
                S_DIV: begin
                    if (w_div_stat.done) begin
                        r_rate <= w_quot;
                    end
                end
                default: begin
                    r_rate <= r_rate;
                end
            endcase
        end
    end

    // Datapath of the current transaction.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    r_fc  <= i_in.frame_count;
                    r_ts  <= i_in.time_ticks;
                    r_upd <= 1'b0;
                end
            end
            S_WRITE: begin
                // The very first stored report reads back the slot it writes.
                r_first <= !w_full && (r_fill == '0);
            end
            S_CHECK: begin
                r_interval <= w_interval;
                r_num      <= r_sum - SUM_W'(w_rd_entry.frames);
            end
            S_MUL: r_prod <= r_num * r_tps;
            S_DIV: begin
                if (w_div_stat.done) begin
                    r_upd <= 1'b1;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out_rate <= r_rate;
                    r_out_upd  <= r_upd;
                end
            end
            default: begin
                r_fc <= r_fc;
            end
        endcase
    end

    // Ring of stored reports.
    swfr_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_entry),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Iterative divider for the rate.
    swfr_divider #(
        .DIVD_W (DIVD_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_div_ctrl),
        .i_dividend ({r_prod, FRAC_W'(0)}),
        .i_divisor  (r_interval),
        .o_stat     (w_div_stat),
        .o_quotient (w_quot)
    );

    assign o_out.valid   = r_out_valid;
    assign o_out.rate_q8 = r_out_rate;
    assign o_out.updated = r_out_upd;

endmodule

`default_nettype wire
